FILE: sv/bnd_pkg.sv
// types and constants shared by the nearest-neighbor demosaic block
// no dependencies
`default_nettype none
package bnd_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned WDimW     = ColW + 1;
  localparam int unsigned HDimW     = RowW + 1;
  localparam int unsigned FwW       = 11;
  localparam int unsigned FhW       = 13;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;
  localparam int unsigned PixW      = 24;

  localparam logic [FwW-1:0] FwReset = FwW'(640);
  localparam logic [FhW-1:0] FhReset = FhW'(480);

  typedef enum logic [0:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;
  } pix_out_t;

endpackage
`default_nettype wire

FILE: sv/bayer_nearest_demosaic_top.sv
// nearest-neighbor bayer demosaic: line buffer memory, position counters, apb registers
// depends on bnd_pkg
// Takes one pixel per clock and returns one pixel per clock while out_stall_i is low.
// An accepted pixel passes through the read stage and then the output register. The
// previous row of finished pixels sits in a 1024 x 24 bit line buffer with one write
// and one registered read port; each pixel reads its column at accept and writes its
// finished value back when it leaves the read stage, with a bypass when both hit the
// same column. With the output stalled the block holds two pixels, one in the read
// stage and one in the output register, and then stalls the input in the same
// cycle. The line buffer needs no clearing after reset. Set frame_width and
// frame_height only while no pixels are in flight.
`default_nettype none
module bayer_nearest_demosaic_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire bnd_pkg::pix_in_t        in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output bnd_pkg::pix_out_t            out_item_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bnd_pkg::*;

  logic [FwW-1:0] fw_q;
  logic [FhW-1:0] fh_q;
  reg_idx_e       reg_idx;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [WDimW-1:0] w_eff;
  logic [HDimW-1:0] h_eff;
  logic             row_end, frame_end, interior;

  logic             s1_valid_q;
  pix_in_t          s1_pix_q;
  logic             s1_xodd_q, s1_yodd_q, s1_int_q, s1_eof_q;
  logic [ColW-1:0]  s1_col_q;
  logic [PixW-1:0]  up_q, ul_q, lf_q, px;

  logic             out_valid_q;
  pix_out_t         out_item_q;

  logic             accept, s1_adv;
  logic [PixW-1:0]  mem [MaxWidth];

  logic [7:0] r, g, b;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegFrameWidth:  prdata = PdataW'(fw_q);
      RegFrameHeight: prdata = PdataW'(fh_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FwReset;
      fh_q <= FhReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        RegFrameWidth:  fw_q <= pwdata[FwW-1:0];
        RegFrameHeight: fh_q <= pwdata[FhW-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..max
  always_comb begin
    if (fw_q == '0) begin
      w_eff = WDimW'(1);
    end else if (32'(fw_q) > MaxWidth) begin
      w_eff = WDimW'(MaxWidth);
    end else begin
      w_eff = WDimW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HDimW'(1);
    end else if (32'(fh_q) > MaxHeight) begin
      h_eff = HDimW'(MaxHeight);
    end else begin
      h_eff = HDimW'(fh_q);
    end
  end

  assign row_end   = ({1'b0, col_q} + WDimW'(1)) >= w_eff;
  assign frame_end = ({1'b0, row_q} + HDimW'(1)) >= h_eff;
  assign interior  = (col_q != '0) && (({1'b0, col_q} + WDimW'(2)) < w_eff) &&
                     (row_q != '0) && (({1'b0, row_q} + HDimW'(2)) < h_eff);

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + RowW'(1);
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lf_q        <= '0;
      ul_q        <= '0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        lf_q        <= px;
        ul_q        <= up_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= in_item_i;
      s1_col_q  <= col_q;
      s1_xodd_q <= col_q[0];
      s1_yodd_q <= row_q[0];
      s1_int_q  <= interior;
      s1_eof_q  <= row_end && frame_end;
    end
    if (s1_adv) begin
      out_item_q <= '{out_red: r, out_green: g, out_blue: b, end_of_frame: s1_eof_q};
    end
  end

  // line buffer with write-to-read bypass
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_col_q] <= px;
    end
    if (accept) begin
      if (s1_adv && (s1_col_q == col_q)) begin
        up_q <= px;
      end else begin
        up_q <= mem[col_q];
      end
    end
  end

  always_comb begin
    r = s1_pix_q.in_red;
    g = s1_pix_q.in_green;
    b = s1_pix_q.in_blue;
    if (s1_int_q) begin
      case ({s1_xodd_q, s1_yodd_q})
        2'b11: begin
          b = lf_q[7:0];
          r = up_q[23:16];
        end
        2'b01: begin
          g = lf_q[15:8];
          r = ul_q[23:16];
        end
        2'b10: begin
          g = lf_q[15:8];
          b = ul_q[7:0];
        end
        default: begin
          r = lf_q[23:16];
          b = up_q[7:0];
        end
      endcase
    end
    px = {r, g, b};
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

FILE: test/bayer_nearest_demosaic_top_tb.sv
// testbench for bayer_nearest_demosaic_top: a pixel predictor with its own line buffer,
// random idle on the input stream and random stall on the output stream, frame size changes through the apb port
// depends on bnd_pkg and the block's rtl
module bayer_nearest_demosaic_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bnd_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomItems = 300;

  class demosaic_checker;
    logic [FwW-1:0]  frame_width;
    logic [FhW-1:0]  frame_height;
    int unsigned     col;
    int unsigned     row;
    logic [PixW-1:0] row_above [MaxWidth];
    logic [PixW-1:0] left_px;
    logic [PixW-1:0] upper_left_px;
    pix_out_t        pending_pixels [$];
    int unsigned     errors;

    function new();
      frame_width   = FwReset;
      frame_height  = FhReset;
      col           = 0;
      row           = 0;
      left_px       = '0;
      upper_left_px = '0;
      errors        = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] value);
      if (idx == RegFrameWidth) begin
        frame_width = value[FwW-1:0];
      end else begin
        frame_height = value[FhW-1:0];
      end
    endfunction

    function int unsigned width_in_use();
      if (frame_width == 0) return 1;
      if (frame_width > MaxWidth) return MaxWidth;
      return frame_width;
    endfunction

    function int unsigned height_in_use();
      if (frame_height == 0) return 1;
      if (frame_height > MaxHeight) return MaxHeight;
      return frame_height;
    endfunction

    function int unsigned pixels_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned n;
      w = width_in_use();
      h = height_in_use();
      n = (col + 1 >= w) ? 1 : w - col;
      if (row + 1 < h) n += (h - 1 - row) * w;
      return n;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void note_input(pix_in_t p);
      int unsigned     w;
      int unsigned     h;
      logic [PixW-1:0] up;
      logic [PixW-1:0] ul;
      logic [PixW-1:0] lf;
      pix_out_t        q;
      w  = width_in_use();
      h  = height_in_use();
      up = row_above[col];
      ul = upper_left_px;
      lf = left_px;
      q.out_red      = p.in_red;
      q.out_green    = p.in_green;
      q.out_blue     = p.in_blue;
      q.end_of_frame = 1'b0;
      if (col >= 1 && col + 2 < w && row >= 1 && row + 2 < h) begin
        if (col % 2 == 1) begin
          if (row % 2 == 1) begin
            q.out_blue = lf[7:0];
            q.out_red  = up[23:16];
          end else begin
            q.out_green = lf[15:8];
            q.out_blue  = ul[7:0];
          end
        end else begin
          if (row % 2 == 1) begin
            q.out_green = lf[15:8];
            q.out_red   = ul[23:16];
          end else begin
            q.out_red  = lf[23:16];
            q.out_blue = up[7:0];
          end
        end
      end
      upper_left_px = up;
      row_above[col] = {q.out_red, q.out_green, q.out_blue};
      left_px = {q.out_red, q.out_green, q.out_blue};
      if (col + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          row = 0;
          q.end_of_frame = 1'b1;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
      pending_pixels.push_back(q);
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel %h with none expected", $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("out_red", want.out_red, got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue", want.out_blue, got.out_blue);
      compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  pix_in_t           in_item;
  logic              out_valid;
  logic              out_stall;
  pix_out_t          out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  demosaic_checker board = new();
  int unsigned     cycle_count = 0;
  int unsigned     random_items = 0;
  bit              no_idle = 1'b0;

  bayer_nearest_demosaic_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) board.note_input(in_item);
    if (rst_ni && out_valid && !out_stall) board.check_result(out_item);
  end

  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(10);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  function automatic pix_in_t rand_pixel();
    pix_in_t     p;
    int unsigned kept;
    p = PixW'($urandom);
    if ($urandom_range(1) == 1) begin
      kept = $urandom_range(2);
      if (kept != 0) p.in_red = '0;
      if (kept != 1) p.in_green = '0;
      if (kept != 2) p.in_blue = '0;
    end
    return p;
  endfunction

  task automatic send_pixel(input pix_in_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= p;
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure_frame(input logic [31:0] width_word, input logic [31:0] height_word);
    logic [31:0] words [2];
    logic [31:0] readback;
    reg_idx_e    idx;
    words[0] = width_word;
    words[1] = height_word;
    for (int k = 0; k < 2; k++) begin
      idx = reg_idx_e'(k);
      readback = (idx == RegFrameWidth) ? 32'(words[k][FwW-1:0]) : 32'(words[k][FhW-1:0]);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= words[k];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      board.set_register(idx, words[k]);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      board.compare_field(idx.name(), readback, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned part;
    pix_in_t     p;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all four parity cases inside a 5 x 5 frame
    configure_frame(5, 5);
    for (int i = 0; i < 25; i++) begin
      p = {8'(i * 53), (i % 2 == 1) ? 8'hFF : 8'h00, (i % 4 < 2) ? 8'h00 : 8'hFF};
      send_pixel(p);
    end
    // zero width and height act as one
    wait_drained();
    configure_frame(0, 0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    wait_drained();
    configure_frame(1, 3);
    send_pixels(3);

    // height above the maximum, then the frame is ended early
    wait_drained();
    configure_frame(0, 8191);
    send_pixels(3);
    wait_drained();
    configure_frame(1, 1);
    send_pixels(board.pixels_to_frame_end());

    // width above the maximum is clamped, then shrunk in the middle of a frame
    wait_drained();
    configure_frame(2047, 2);
    send_pixels(MaxWidth + $urandom_range(1, 5));
    wait_drained();
    configure_frame(4, 1);
    send_pixels(board.pixels_to_frame_end());

    while (random_items < RandomItems) begin
      wait_drained();
      no_idle = ($urandom_range(3) == 0);
      w = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      h = ($urandom_range(7) == 0) ? $urandom_range(11, 13) : $urandom_range(1, 10);
      configure_frame(w, h);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        if ($urandom_range(4) == 0 && w * h > 2) begin
          part = $urandom_range(1, w * h - 1);
          send_pixels(part);
          random_items += part;
          wait_drained();
          w = $urandom_range(1, w);
          h = $urandom_range(1, h + 3);
          configure_frame(w, h);
          part = board.pixels_to_frame_end();
          send_pixels(part);
          random_items += part;
        end else begin
          send_pixels(w * h);
          random_items += w * h;
        end
        if ($urandom_range(7) == 0) wait_drained();
      end
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: bayer_nearest_demosaic_top.f
sv/bnd_pkg.sv
sv/bayer_nearest_demosaic_top.sv
test/bayer_nearest_demosaic_top_tb.sv
